FILE: rtl/haar_dwt_2d_forward_top_macros.svh
// Assertion helpers shared by the RTL
`ifndef HAAR_DWT_2D_FORWARD_TOP_MACROS_SVH
`define HAAR_DWT_2D_FORWARD_TOP_MACROS_SVH

// same-cycle implication
`define HDWT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDWT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hdwt_pkg.sv
`default_nettype none

package hdwt_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CFG_W     = 12;
  localparam int PIX_W     = 8;
  localparam int LL_W      = 17;
  localparam int COEF_W    = 18;
  localparam int BCOL_W    = ADDR_W - 1;
  localparam int SUM_W     = PIX_W + 3;
  localparam int SCALE_W   = 16;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = SUM_W + SCALE_W + 1;
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;

  // 0.707^2 in Q.16
  localparam logic [SCALE_W-1:0] SCALE_NUM = 16'd32758;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd640;

  // register index codes
  localparam logic [PADDR_W-3:0] REG_LINE_WIDTH = '0;

  // floor(s * SCALE_NUM / 256)
  function automatic logic [COEF_W-1:0] scale_q8(input logic signed [SUM_W-1:0] s);
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(s) * $signed({1'b0, SCALE_NUM});
    return prod[FRAC_W +: COEF_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hdwt_ram.sv
`default_nettype none

module hdwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/haar_dwt_2d_forward_top.sv
// One-level forward 2D Haar transform on a raster stream of 8-bit gray pixels.
// Input channel: in_valid_i / in_stall_o with pixel_i and frame_start_i; a
//   transaction completes when valid is high and stall is low. frame_start_i on
//   a pixel makes it column 0 of an even row.
// Output channel: out_valid_o / out_stall_i with ll_o, lh_o, hl_o, hh_o,
//   block_col_o and row_end_o. One transaction per 2x2 block, issued on the
//   odd column of each odd row; other pixels give no output.
// Configuration: APB register 0 (byte address 0) holds line_width, reset 640.
//   Write it only while the block is idle.
// Throughput: one pixel per clock while in_stall_o is low; each pixel makes one line buffer access.
// Path: the completing pixel is taken into the input register together with the
//   line buffer read, then goes through the four 11x16 scaling multipliers into
//   the output register, which drives out_valid_o.
// Stall: while out_stall_i holds a result, pixels without output keep flowing
//   through the input register; once a result-bearing pixel reaches it,
//   in_stall_o stays high until the held result is taken.
// Reset: position goes to column 0 of an even row, line_width to 640 and the
//   output empties. The line buffer is not cleared; every even row is written
//   before the odd row below reads it.
`default_nettype none
`include "haar_dwt_2d_forward_top_macros.svh"

module haar_dwt_2d_forward_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hdwt_pkg::PADDR_W-1:0]         paddr,
  input  logic [hdwt_pkg::APB_DW-1:0]          pwdata,
  output logic [hdwt_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [hdwt_pkg::PIX_W-1:0]           pixel_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [hdwt_pkg::LL_W-1:0]            ll_o,
  output logic [hdwt_pkg::COEF_W-1:0]          lh_o,
  output logic [hdwt_pkg::COEF_W-1:0]          hl_o,
  output logic [hdwt_pkg::COEF_W-1:0]          hh_o,
  output logic [hdwt_pkg::BCOL_W-1:0]          block_col_o,
  output logic                                 row_end_o
);

  import hdwt_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic              odd_row;
    logic              col_odd;
    logic [BCOL_W-1:0] block_col;
    logic              last;
  } s1_t;

  logic [CFG_W-1:0]  line_width_q, line_width_d;
  logic [ADDR_W-1:0] col_pos_q, col_pos_d;
  logic              odd_row_q, odd_row_d;
  logic              s1_valid_q, s1_valid_d;
  s1_t               s1_q;
  logic [PIX_W-1:0]  left_top_q, left_bottom_q;
  logic              out_valid_q, out_valid_d;
  logic [LL_W-1:0]   ll_q;
  logic [COEF_W-1:0] lh_q, hl_q, hh_q;
  logic [BCOL_W-1:0] block_col_q;
  logic              row_end_q;

  logic              cfg_sel, cfg_wr;
  logic [CFG_W-1:0]  w_clamp, eff_w;
  logic [ADDR_W-1:0] col_base, col_addr;
  logic              odd_base, beyond, last;
  logic              accept, ram_we, ram_re;
  logic [PIX_W-1:0]  ram_rdata;
  logic              s1_has_result, s1_move, s1_ready, out_free, out_load, left_load;
  logic signed [SUM_W-1:0] pa, pb, pc, pd, vs_l, vs_r, vd_l, vd_r;
  logic [COEF_W-1:0] ll_full;

  // configuration
  assign cfg_sel      = (paddr[PADDR_W-1:2] == REG_LINE_WIDTH);
  assign cfg_wr       = psel && penable && pwrite && pready && cfg_sel;
  assign line_width_d = cfg_wr ? pwdata[CFG_W-1:0] : line_width_q;
  assign pready       = 1'b1;
  assign prdata       = cfg_sel ? APB_DW'(line_width_q) : '0;

  always_comb begin
    w_clamp = (line_width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : line_width_q;
    eff_w   = {w_clamp[CFG_W-1:1], 1'b0};
    if (eff_w < CFG_W'(2)) begin
      eff_w = CFG_W'(2);
    end
  end

  // position tracking
  assign accept   = in_valid_i && !in_stall_o;
  assign col_base = frame_start_i ? '0 : col_pos_q;
  assign odd_base = frame_start_i ? 1'b0 : odd_row_q;
  assign beyond   = CFG_W'(col_base) >= eff_w;
  assign col_addr = beyond ? ADDR_W'(eff_w - CFG_W'(1)) : col_base;
  assign last     = (CFG_W'(col_base) + CFG_W'(1)) >= eff_w;

  assign col_pos_d = !accept ? col_pos_q : (last ? '0 : col_base + ADDR_W'(1));
  assign odd_row_d = accept ? (odd_base ^ last) : odd_row_q;

  assign ram_we = accept && !odd_base;
  assign ram_re = accept && odd_base;

  hdwt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_addr),
    .wdata_i (pixel_i),
    .re_i    (ram_re),
    .raddr_i (col_addr),
    .rdata_o (ram_rdata)
  );

  // flow control
  assign s1_has_result = s1_q.odd_row && s1_q.col_odd;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign s1_move       = s1_valid_q && (!s1_has_result || out_free);
  assign s1_ready      = !s1_valid_q || s1_move;
  assign in_stall_o    = !s1_ready;
  assign out_load      = s1_move && s1_has_result;
  assign left_load     = s1_move && s1_q.odd_row && !s1_q.col_odd;

  assign s1_valid_d  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  // 2x2 block arithmetic
  assign pa   = $signed(SUM_W'(left_top_q));
  assign pb   = $signed(SUM_W'(ram_rdata));
  assign pc   = $signed(SUM_W'(left_bottom_q));
  assign pd   = $signed(SUM_W'(s1_q.pixel));
  assign vs_l = pa + pc;
  assign vs_r = pb + pd;
  assign vd_l = pa - pc;
  assign vd_r = pb - pd;
  assign ll_full = scale_q8(vs_l + vs_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q  <= LINE_WIDTH_RST;
      col_pos_q     <= '0;
      odd_row_q     <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      left_top_q    <= '0;
      left_bottom_q <= '0;
    end else begin
      line_width_q <= line_width_d;
      col_pos_q    <= col_pos_d;
      odd_row_q    <= odd_row_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      if (left_load) begin
        left_top_q    <= ram_rdata;
        left_bottom_q <= s1_q.pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pixel     <= pixel_i;
      s1_q.odd_row   <= odd_base;
      s1_q.col_odd   <= col_base[0];
      s1_q.block_col <= col_base[ADDR_W-1:1];
      s1_q.last      <= last;
    end
    if (out_load) begin
      ll_q        <= ll_full[LL_W-1:0];
      lh_q        <= scale_q8(vs_l - vs_r);
      hl_q        <= scale_q8(vd_l + vd_r);
      hh_q        <= scale_q8(vd_l - vd_r);
      block_col_q <= s1_q.block_col;
      row_end_q   <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ll_o        = ll_q;
  assign lh_o        = lh_q;
  assign hl_o        = hl_q;
  assign hh_o        = hh_q;
  assign block_col_o = block_col_q;
  assign row_end_o   = row_end_q;

  `HDWT_ASSERT_IMP(a_ram_one_op, ram_we || ram_re, ram_we != ram_re, "line buffer read and write")
  `HDWT_ASSERT_NXT(a_s1_held, s1_valid_q && !s1_ready, s1_valid_q, "input register item lost")
  `HDWT_ASSERT_IMP(a_out_source, $rose(out_valid_q), $past(out_load), "output without block")

endmodule

`default_nettype wire

FILE: dv/tb_haar_dwt_2d_forward_top.sv
typedef struct packed {
  logic [hdwt_pkg::LL_W-1:0]   ll;
  logic [hdwt_pkg::COEF_W-1:0] lh;
  logic [hdwt_pkg::COEF_W-1:0] hl;
  logic [hdwt_pkg::COEF_W-1:0] hh;
  logic [hdwt_pkg::BCOL_W-1:0] bcol;
  logic                        row_end;
} haar_block_t;

class haar_scoreboard;
  logic [hdwt_pkg::PIX_W-1:0] row_buf [hdwt_pkg::MAX_WIDTH];
  bit                         written [hdwt_pkg::MAX_WIDTH];
  int                         col_pos;
  bit                         odd_row;
  logic [hdwt_pkg::PIX_W-1:0] top_left;
  logic [hdwt_pkg::PIX_W-1:0] bottom_left;
  logic [hdwt_pkg::CFG_W-1:0] width_reg;
  haar_block_t                blocks_due[$];
  int                         mismatches;
  int                         blocks_ok;
  int                         pixels_seen;

  function new();
    col_pos     = 0;
    odd_row     = 0;
    top_left    = '0;
    bottom_left = '0;
    width_reg   = hdwt_pkg::LINE_WIDTH_RST;
    mismatches  = 0;
    blocks_ok   = 0;
    pixels_seen = 0;
    foreach (written[i]) written[i] = 0;
  endfunction

  function void write_reg(logic [hdwt_pkg::PADDR_W-3:0] idx, logic [hdwt_pkg::CFG_W-1:0] v);
    if (idx == hdwt_pkg::REG_LINE_WIDTH) width_reg = v;
  endfunction

  function int eff_width(logic [hdwt_pkg::CFG_W-1:0] w);
    int v;
    v = int'(w);
    if (v > hdwt_pkg::MAX_WIDTH) v = hdwt_pkg::MAX_WIDTH;
    v = v & ~1;
    if (v < 2) v = 2;
    return v;
  endfunction

  // every entry an odd row could read at this width has been filled
  function bit store_covers(logic [hdwt_pkg::CFG_W-1:0] w);
    int n;
    n = eff_width(w);
    for (int i = 0; i < n; i++) if (!written[i]) return 0;
    return 1;
  endfunction

  // floor(s * 0.707^2) in Q.8
  function logic [hdwt_pkg::COEF_W-1:0] scale_q8(int s);
    int p;
    p = s * int'(hdwt_pkg::SCALE_NUM);
    p = p >>> 8;
    return p[hdwt_pkg::COEF_W-1:0];
  endfunction

  function void note_pixel(logic [hdwt_pkg::PIX_W-1:0] pix, logic fs);
    int          w, c;
    bit          last;
    int          vsl, vsr, vdl, vdr;
    logic [hdwt_pkg::COEF_W-1:0] llw;
    haar_block_t blk;
    pixels_seen++;
    w = eff_width(width_reg);
    if (fs) begin
      col_pos = 0;
      odd_row = 0;
    end
    c    = (col_pos >= w) ? w - 1 : col_pos;
    last = (col_pos + 1 >= w);
    if (!odd_row) begin
      row_buf[c] = pix;
      written[c] = 1;
    end else if (col_pos[0] == 1'b0) begin
      top_left    = row_buf[c];
      bottom_left = pix;
    end else begin
      vsl = int'(top_left) + int'(bottom_left);
      vsr = int'(row_buf[c]) + int'(pix);
      vdl = int'(top_left) - int'(bottom_left);
      vdr = int'(row_buf[c]) - int'(pix);
      llw         = scale_q8(vsl + vsr);
      blk.ll      = llw[hdwt_pkg::LL_W-1:0];
      blk.lh      = scale_q8(vsl - vsr);
      blk.hl      = scale_q8(vdl + vdr);
      blk.hh      = scale_q8(vdl - vdr);
      blk.bcol    = col_pos[hdwt_pkg::BCOL_W:1];
      blk.row_end = last;
      blocks_due.push_back(blk);
    end
    if (last) begin
      col_pos = 0;
      odd_row = ~odd_row;
    end else begin
      col_pos = (col_pos + 1) & 32'h7FFF;
    end
  endfunction

  function void check_block(haar_block_t got);
    haar_block_t want;
    if (blocks_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected block: ll=%0d lh=%0d hl=%0d hh=%0d col=%0d end=%0b",
                 got.ll, $signed(got.lh), $signed(got.hl), $signed(got.hh),
                 got.bcol, got.row_end);
      return;
    end
    want = blocks_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("block mismatch exp: ll=%0d lh=%0d hl=%0d hh=%0d col=%0d end=%0b",
                 want.ll, $signed(want.lh), $signed(want.hl), $signed(want.hh),
                 want.bcol, want.row_end);
        $display("               got: ll=%0d lh=%0d hl=%0d hh=%0d col=%0d end=%0b",
                 got.ll, $signed(got.lh), $signed(got.hl), $signed(got.hh),
                 got.bcol, got.row_end);
      end
    end else begin
      blocks_ok++;
    end
  endfunction
endclass

module tb_haar_dwt_2d_forward_top;
  import hdwt_pkg::*;

  localparam logic [PADDR_W-3:0] REG_UNUSED = 1'b1;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PIX_W-1:0]    pixel_i;
  logic                frame_start_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [LL_W-1:0]     ll_o;
  logic [COEF_W-1:0]   lh_o;
  logic [COEF_W-1:0]   hl_o;
  logic [COEF_W-1:0]   hh_o;
  logic [BCOL_W-1:0]   block_col_o;
  logic                row_end_o;

  haar_scoreboard sb;
  int             src_gap_pct;
  int             snk_gap_pct;
  int             hold_cycles;
  int             width_writes;

  haar_dwt_2d_forward_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ll_o          (ll_o),
    .lh_o          (lh_o),
    .hl_o          (hl_o),
    .hh_o          (hh_o),
    .block_col_o   (block_col_o),
    .row_end_o     (row_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[haar_dwt_2d_forward_top] ERROR");
    $finish;
  end

  // result transactions
  initial begin
    haar_block_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {ll_o, lh_o, hl_o, hh_o, block_col_o, row_end_o};
        sb.check_block(got);
      end
    end
  end

  // receiver stall: short random bursts, or one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (snk_gap_pct > 0 && $urandom_range(0, 99) < snk_gap_pct) begin
        n = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic apb_write(input logic [PADDR_W-3:0] idx, input logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'($urandom()), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic check_width();
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_LINE_WIDTH, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[CFG_W-1:0] !== sb.width_reg) begin
      sb.mismatches++;
      if (sb.mismatches <= 10)
        $display("line_width readback: exp %0d got %0d", sb.width_reg, rd[CFG_W-1:0]);
    end
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs);
    int gap;
    if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= p;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(p, fs);
  endtask

  // wait out all blocks plus the pipeline before touching the register
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.blocks_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    apb_write(REG_LINE_WIDTH, w);
    width_writes++;
    check_width();
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input int n, input bit keep_pos);
    logic [PIX_W-1:0] p;
    logic             fs;
    int               flavour;
    set_width(w);
    flavour = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (flavour)
        1:       p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2:       p = PIX_W'($urandom_range(120, 135));
        default: p = PIX_W'($urandom_range(0, 255));
      endcase
      if (i == 0)
        fs = !sb.store_covers(w) || (!keep_pos && $urandom_range(0, 1) == 1);
      else
        fs = ($urandom_range(0, 99) == 0);
      send_pixel(p, fs);
    end
    settle();
  endtask

  initial begin
    logic [PIX_W-1:0] blk_px [6][4];
    logic [CFG_W-1:0] w;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    pixel_i       = '0;
    frame_start_i = 1'b0;
    out_stall_i   = 1'b0;
    src_gap_pct   = 0;
    snk_gap_pct   = 0;
    hold_cycles   = 0;
    width_writes  = 0;
    sb            = new();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_width();
    apb_write(REG_UNUSED, 12'hABC);
    check_width();

    // corner 2x2 blocks: A B on the even row, C D below
    blk_px = '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00, 8'h00},
               '{8'hFF, 8'h00, 8'hFF, 8'h00}, '{8'h00, 8'hFF, 8'h00, 8'hFF},
               '{8'hFF, 8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'hFF, 8'h00}};
    set_width(12'd2);
    src_gap_pct = 20;
    snk_gap_pct = 20;
    for (int b = 0; b < 6; b++)
      for (int k = 0; k < 4; k++) send_pixel(blk_px[b][k], (b == 0 && k == 0));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0:       w = CFG_W'($urandom_range(0, 3));
        default: w = CFG_W'($urandom_range(2, 48));
      endcase
      src_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      snk_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      run_phase(w, $urandom_range(60, 90), 1'($urandom_range(0, 1)));
    end

    // long receiver hold-off so the block backs up into its input
    src_gap_pct = 0;
    snk_gap_pct = 10;
    hold_cycles = 400;
    run_phase(12'd4, 200, 0);

    src_gap_pct = 5;
    snk_gap_pct = 5;
    run_phase(12'd400, 800, 0);

    // clamp above the buffer, then a lower width with the column already past it
    run_phase(12'hFFF, 200, 0);
    run_phase(12'd6, 60, 1);

    src_gap_pct = 0;
    snk_gap_pct = 0;
    run_phase(CFG_W'($urandom_range(2, 32)), 150, 0);
    run_phase(12'd1, 60, 1);

    $display("checked %0d blocks from %0d pixels over %0d line_width settings",
             sb.blocks_ok, sb.pixels_seen, width_writes);
    $display("widths from the low clamp to the buffer-size clamp, with a long receiver hold-off");
    if (sb.mismatches == 0 && sb.blocks_due.size() == 0) begin
      $display("[haar_dwt_2d_forward_top] OK");
    end else begin
      $display("[haar_dwt_2d_forward_top] ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/hdwt_pkg.sv
rtl/hdwt_ram.sv
rtl/haar_dwt_2d_forward_top.sv
dv/tb_haar_dwt_2d_forward_top.sv
